FILE: rtl/psds_pkg.sv
// Constants, widths and types shared by the point to segment distance search pipeline.
`timescale 1ns / 1ps

package psds_pkg;

	localparam int COORD_BITS  = 16;
	localparam int T_FRAC_BITS = 20;
	localparam int EPSILON_Q   = 105;
	localparam int LEVEL_CAP   = T_FRAC_BITS + 2;

	localparam int OUT_W  = 17;
	localparam int DIFF_W = COORD_BITS + 1;
	localparam int Q_W    = T_FRAC_BITS + 2;
	localparam int D_W    = Q_W + DIFF_W + 1;
	localparam int MAG_W  = D_W - 1;
	localparam int LO_W   = MAG_W / 2;
	localparam int HI_W   = MAG_W - LO_W;
	localparam int SQ_W   = 2 * MAG_W + 2;
	localparam int RAD_W  = SQ_W - 2 * T_FRAC_BITS + 1;
	localparam int ROOT_W = (RAD_W + 1) / 2;

	// Levels needed in the worst case: walk the interval width, keeping the larger half.
	function automatic int num_levels();
		longint w;
		int     n;
		logic   stop;
		w    = longint'(1) << T_FRAC_BITS;
		n    = 0;
		stop = 1'b0;
		for (int i = 0; i < LEVEL_CAP; i++) begin
			if (!stop) begin
				n = n + 1;
				if ((w >> 1) + longint'(EPSILON_Q) > w)
					stop = 1'b1;
				else
					w = w - (w >> 1);
			end
		end
		return n;
	endfunction

	localparam int NUM_LEVELS = num_levels();

	typedef struct packed {
		logic [2:0][DIFF_W-1:0] c;	// A - P per axis
		logic [2:0][DIFF_W-1:0] v;	// B - A per axis
	} geo_t;

	typedef struct packed {
		logic            done;
		logic            brk;
		logic [Q_W-1:0]  lt;
		logic [Q_W-1:0]  mid;
		logic [Q_W-1:0]  rt;
		logic [SQ_W-1:0] best;
		geo_t            geo;
	} ctx_t;

endpackage

FILE: rtl/point_segment_distance_search.sv
// Point to segment distance search: halving pipeline on t, then a digit-serial ceiling root.
`timescale 1ns / 1ps

// Takes one transaction per clock and returns one distance per transaction, in order.
// The pipeline has one entry stage, eight stages for each search level (midpoint, probe
// offsets, magnitude, split squares, recombine, axis sum, compare, minimum), one stage to
// scale the minimum, one stage per root bit and the output register. Every stage is
// a register stage under one enable, so out_stall holding a result freezes the whole
// pipeline and is passed straight to in_stall; nothing is lost or duplicated.
module point_segment_distance_search (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 in_valid,
	output logic                                 in_stall,
	input  logic signed [psds_pkg::COORD_BITS-1:0] a_x,
	input  logic signed [psds_pkg::COORD_BITS-1:0] a_y,
	input  logic signed [psds_pkg::COORD_BITS-1:0] a_z,
	input  logic signed [psds_pkg::COORD_BITS-1:0] b_x,
	input  logic signed [psds_pkg::COORD_BITS-1:0] b_y,
	input  logic signed [psds_pkg::COORD_BITS-1:0] b_z,
	input  logic signed [psds_pkg::COORD_BITS-1:0] p_x,
	input  logic signed [psds_pkg::COORD_BITS-1:0] p_y,
	input  logic signed [psds_pkg::COORD_BITS-1:0] p_z,
	output logic                                 out_valid,
	input  logic                                 out_stall,
	output logic [psds_pkg::OUT_W-1:0]           distance_ceil
);

	localparam int NL     = psds_pkg::NUM_LEVELS;
	localparam int TF     = psds_pkg::T_FRAC_BITS;
	localparam int FR2    = 2 * psds_pkg::T_FRAC_BITS;
	localparam int DIFF_W = psds_pkg::DIFF_W;
	localparam int Q_W    = psds_pkg::Q_W;
	localparam int D_W    = psds_pkg::D_W;
	localparam int MAG_W  = psds_pkg::MAG_W;
	localparam int LO_W   = psds_pkg::LO_W;
	localparam int HI_W   = psds_pkg::HI_W;
	localparam int SQ_W   = psds_pkg::SQ_W;
	localparam int ROOT_W = psds_pkg::ROOT_W;
	localparam int OUT_W  = psds_pkg::OUT_W;

	localparam logic signed [Q_W-1:0] EPS_Q = Q_W'(psds_pkg::EPSILON_Q);
	localparam logic signed [Q_W:0]   EPS_X = (Q_W+1)'(psds_pkg::EPSILON_Q);
	localparam logic [Q_W-1:0]        T_ONE = Q_W'(1) << TF;

	logic en;

	assign en       = !(out_valid && out_stall);
	assign in_stall = !en;

	// Entry stage: differences A-P and B-A
	logic           vld_s0;
	psds_pkg::geo_t geo_s0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s0 <= 1'b0;
		end else if (en) begin
			vld_s0 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			geo_s0.c[0] <= DIFF_W'(a_x) - DIFF_W'(p_x);
			geo_s0.c[1] <= DIFF_W'(a_y) - DIFF_W'(p_y);
			geo_s0.c[2] <= DIFF_W'(a_z) - DIFF_W'(p_z);
			geo_s0.v[0] <= DIFF_W'(b_x) - DIFF_W'(a_x);
			geo_s0.v[1] <= DIFF_W'(b_y) - DIFF_W'(a_y);
			geo_s0.v[2] <= DIFF_W'(b_z) - DIFF_W'(a_z);
		end
	end

	logic           lvl_vld [NL+1];
	psds_pkg::ctx_t lvl_ctx [NL+1];

	assign lvl_vld[0] = vld_s0;
	assign lvl_ctx[0] = '{done: 1'b0, brk: 1'b0, lt: '0, mid: '0, rt: T_ONE,
			best: '1, geo: geo_s0};

	for (genvar lv = 0; lv < NL; lv++) begin : g_lvl
		logic [8:1]            vld_s;
		psds_pkg::ctx_t        ctx_s1, ctx_s2, ctx_s3, ctx_s4, ctx_s5, ctx_s6, ctx_s7, ctx_s8;
		logic signed [Q_W-1:0] q_s1   [3];
		logic signed [D_W-1:0] d_s2   [3][3];
		logic [MAG_W-1:0]      mag_s3 [3][3];
		logic [2*HI_W-1:0]     hh_s4  [3][3];
		logic [MAG_W-1:0]      hl_s4  [3][3];
		logic [2*LO_W-1:0]     ll_s4  [3][3];
		logic [2*MAG_W-1:0]    sqa_s5 [3][3];
		logic [SQ_W-1:0]       f_s6   [3];
		logic [SQ_W-1:0]       m1_s7, m2_s7;

		logic signed [Q_W:0]   sum_w;
		logic signed [Q_W-1:0] mid_w;
		logic                  brk_w;
		psds_pkg::ctx_t        ctx1_w;
		psds_pkg::ctx_t        ctx_w;
		psds_pkg::ctx_t        ctx8_w;
		logic [SQ_W-1:0]       m1_w, m2_w;

		always_comb begin
			sum_w = $signed({lvl_ctx[lv].lt[Q_W-1], lvl_ctx[lv].lt})
				+ $signed({lvl_ctx[lv].rt[Q_W-1], lvl_ctx[lv].rt});
			mid_w = sum_w[Q_W:1];
			brk_w = ($signed({mid_w[Q_W-1], mid_w}) + EPS_X)
				> $signed({lvl_ctx[lv].rt[Q_W-1], lvl_ctx[lv].rt});
			ctx1_w     = lvl_ctx[lv];
			ctx1_w.mid = mid_w;
			ctx1_w.brk = brk_w;
		end

		// Running minimum and choice of half; ties keep the left half
		always_comb begin
			ctx_w = ctx_s6;
			m1_w  = ctx_s6.best;
			m2_w  = '1;
			if (!ctx_s6.done) begin
				if (f_s6[0] < ctx_s6.best)
					m1_w = f_s6[0];
				if (ctx_s6.brk) begin
					ctx_w.done = 1'b1;
				end else begin
					m2_w = (f_s6[2] < f_s6[1]) ? f_s6[2] : f_s6[1];
					if (f_s6[1] > f_s6[2])
						ctx_w.lt = ctx_s6.mid;
					else
						ctx_w.rt = ctx_s6.mid;
				end
			end
		end

		always_comb begin
			ctx8_w      = ctx_s7;
			ctx8_w.best = (m2_s7 < m1_s7) ? m2_s7 : m1_s7;
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s <= '0;
			end else if (en) begin
				vld_s <= {vld_s[7:1], lvl_vld[lv]};
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				ctx_s1     <= ctx1_w;
				q_s1[0]    <= mid_w;
				q_s1[1]    <= mid_w - EPS_Q;
				q_s1[2]    <= mid_w + EPS_Q;

				ctx_s2 <= ctx_s1;
				ctx_s3 <= ctx_s2;
				ctx_s4 <= ctx_s3;
				ctx_s5 <= ctx_s4;
				ctx_s6 <= ctx_s5;
				for (int p = 0; p < 3; p++) begin
					for (int a = 0; a < 3; a++) begin
						d_s2[p][a] <= (D_W'($signed(ctx_s1.geo.c[a])) <<< TF)
							+ D_W'(q_s1[p]) * D_W'($signed(ctx_s1.geo.v[a]));
						mag_s3[p][a] <= d_s2[p][a][D_W-1] ? MAG_W'(-d_s2[p][a])
							: MAG_W'(d_s2[p][a]);
						hh_s4[p][a] <= (2*HI_W)'(mag_s3[p][a][MAG_W-1:LO_W])
							* (2*HI_W)'(mag_s3[p][a][MAG_W-1:LO_W]);
						hl_s4[p][a] <= MAG_W'(mag_s3[p][a][MAG_W-1:LO_W])
							* MAG_W'(mag_s3[p][a][LO_W-1:0]);
						ll_s4[p][a] <= (2*LO_W)'(mag_s3[p][a][LO_W-1:0])
							* (2*LO_W)'(mag_s3[p][a][LO_W-1:0]);
						sqa_s5[p][a] <= ((2*MAG_W)'(hh_s4[p][a]) << (2*LO_W))
							+ ((2*MAG_W)'(hl_s4[p][a]) << (LO_W+1))
							+ (2*MAG_W)'(ll_s4[p][a]);
					end
					f_s6[p] <= SQ_W'(sqa_s5[p][0]) + SQ_W'(sqa_s5[p][1])
						+ SQ_W'(sqa_s5[p][2]);
				end

				ctx_s7 <= ctx_w;
				m1_s7  <= m1_w;
				m2_s7  <= m2_w;

				ctx_s8 <= ctx8_w;
			end
		end

		assign lvl_vld[lv+1] = vld_s[8];
		assign lvl_ctx[lv+1] = ctx_s8;
	end

	// Ceiling root: radicand is the minimum scaled down by 2^(2*TF), rounded up
	logic [ROOT_W:0]     sq_vld_s;
	logic [2*ROOT_W-1:0] sq_rad_s  [ROOT_W+1];
	logic [ROOT_W-1:0]   sq_root_s [ROOT_W+1];
	logic [ROOT_W+1:0]   sq_rem_s  [ROOT_W+1];
	logic [ROOT_W+1:0]   cur_w     [ROOT_W];
	logic [ROOT_W+1:0]   trial_w   [ROOT_W];

	always_comb begin
		for (int k = 0; k < ROOT_W; k++) begin
			cur_w[k]   = {sq_rem_s[k][ROOT_W-1:0], sq_rad_s[k][2*(ROOT_W-1-k)+1 -: 2]};
			trial_w[k] = {sq_root_s[k], 2'b01};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sq_vld_s <= '0;
		end else if (en) begin
			sq_vld_s <= {sq_vld_s[ROOT_W-1:0], lvl_vld[NL]};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sq_rad_s[0]  <= (2*ROOT_W)'(lvl_ctx[NL].best >> FR2)
				+ (2*ROOT_W)'(|lvl_ctx[NL].best[FR2-1:0]);
			sq_root_s[0] <= '0;
			sq_rem_s[0]  <= '0;
			for (int k = 0; k < ROOT_W; k++) begin
				sq_rad_s[k+1] <= sq_rad_s[k];
				if (cur_w[k] >= trial_w[k]) begin
					sq_rem_s[k+1]  <= cur_w[k] - trial_w[k];
					sq_root_s[k+1] <= {sq_root_s[k][ROOT_W-2:0], 1'b1};
				end else begin
					sq_rem_s[k+1]  <= cur_w[k];
					sq_root_s[k+1] <= {sq_root_s[k][ROOT_W-2:0], 1'b0};
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (en) begin
			out_valid <= sq_vld_s[ROOT_W];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			distance_ceil <= OUT_W'((ROOT_W+1)'(sq_root_s[ROOT_W])
				+ (ROOT_W+1)'(sq_rem_s[ROOT_W] != '0));
		end
	end

endmodule
